// ===== src/slcd_pkg.sv =====
// Package for the sync/length/checksum deframer.
// Holds the request and result types, the deframer phase enum and the
// default size; used by slcd_core and the top-level deframer.
`timescale 1ns / 1ps

package slcd_pkg;

   // Default capacity of one frame in 16-bit words
   localparam int SLCD_MAX_WORDS = 16;

   localparam logic [7:0] SLCD_SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SLCD_ZERO_BYTE = 8'h00;
   localparam logic [7:0] SLCD_HDR_BYTES = 8'd3;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_LEN   = 3'd2,
      PH_ZERO  = 3'd3,
      PH_LOW   = 3'd4,
      PH_HIGH  = 3'd5
   } slcd_phase_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } slcd_request_type;

   typedef struct packed {
      logic        word_valid;
      logic [15:0] word_value;
      logic [3:0]  word_index;
      logic        frame_good;
      logic        frame_error;
      logic [4:0]  word_count;
      logic        byte_dropped;
   } slcd_result_type;

endpackage

// ===== src/slcd_stage.sv =====
// One valid/ready register stage for the deframer datapath.
// Depends on nothing; width is set by the instantiating module.
`timescale 1ns / 1ps

module slcd_stage #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   // take a new request whenever the held one leaves or none is held
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== src/slcd_core.sv =====
// Deframer state and per-byte decision logic.
// Uses slcd_pkg for the phase enum and the request/result types.
`timescale 1ns / 1ps

module slcd_core #(
   parameter int MAX_WORDS = slcd_pkg::SLCD_MAX_WORDS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  slcd_pkg::slcd_request_type request,
   output slcd_pkg::slcd_result_type  result
);

   import slcd_pkg::*;

   localparam int CNT_W   = ($clog2(MAX_WORDS + 1) > 5) ? $clog2(MAX_WORDS + 1) : 5;
   localparam int MAX_LEN = 2 * MAX_WORDS + 3;

   slcd_phase_type   phase_ff,       phase_in;
   logic [7:0]       bytes_left_ff,  bytes_left_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [7:0]       low_byte_ff,    low_byte_in;
   logic [CNT_W-1:0] words_seen_ff,  words_seen_in;
   logic             frame_held_ff,  frame_held_in;

   logic [7:0] sum_add;
   logic       len_bad;

   assign sum_add = running_sum_ff + request.rx_byte;
   assign len_bad = (request.rx_byte < SLCD_HDR_BYTES) || !request.rx_byte[0] ||
                    (9'(request.rx_byte) > 9'(MAX_LEN));

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      low_byte_in    = low_byte_ff;
      words_seen_in  = words_seen_ff;
      frame_held_in  = frame_held_ff;
      if (request.action) begin
         frame_held_in = 1'b0;
      end else if (!frame_held_ff) begin
         case (phase_ff)
            PH_SYNC2: begin
               phase_in = (request.rx_byte == SLCD_SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
               if (len_bad) begin
                  phase_in = PH_SYNC1;
               end else begin
                  bytes_left_in  = request.rx_byte - SLCD_HDR_BYTES;
                  running_sum_in = '0;
                  words_seen_in  = '0;
                  phase_in       = PH_ZERO;
               end
            end
            PH_ZERO: begin
               phase_in = (request.rx_byte == SLCD_ZERO_BYTE) ? PH_LOW : PH_SYNC1;
            end
            PH_LOW: begin
               if (bytes_left_ff == '0) begin
                  frame_held_in  = (sum_add == '0);
                  running_sum_in = '0;
                  words_seen_in  = '0;
                  phase_in       = PH_SYNC1;
               end else begin
                  running_sum_in = sum_add;
                  low_byte_in    = request.rx_byte;
                  phase_in       = PH_HIGH;
               end
            end
            PH_HIGH: begin
               running_sum_in = sum_add;
               words_seen_in  = words_seen_ff + CNT_W'(1);
               bytes_left_in  = bytes_left_ff - 8'd2;
               phase_in       = PH_LOW;
            end
            default: begin
               phase_in = (request.rx_byte == SLCD_SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   // result for this request
   always_comb begin
      result = '0;
      if (!request.action) begin
         if (frame_held_ff) begin
            result.byte_dropped = 1'b1;
         end else begin
            case (phase_ff)
               PH_LEN: begin
                  result.frame_error = len_bad;
               end
               PH_ZERO: begin
                  result.frame_error = (request.rx_byte != SLCD_ZERO_BYTE);
               end
               PH_LOW: begin
                  if (bytes_left_ff == '0) begin
                     if (sum_add == '0) begin
                        result.frame_good = 1'b1;
                        result.word_count = words_seen_ff[4:0];
                     end else begin
                        result.frame_error = 1'b1;
                     end
                  end
               end
               PH_HIGH: begin
                  result.word_valid = 1'b1;
                  result.word_value = {request.rx_byte, low_byte_ff};
                  result.word_index = words_seen_ff[3:0];
               end
               default: begin
                  result = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SYNC1;
         bytes_left_ff  <= '0;
         running_sum_ff <= '0;
         words_seen_ff  <= '0;
         frame_held_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
         words_seen_ff  <= words_seen_in;
         frame_held_ff  <= frame_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         low_byte_ff <= low_byte_in;
      end
   end

   a_good_holds: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_good |=> frame_held_ff)
      else $error("good frame did not set the hold");

   a_held_drops: assert property (@(posedge clock) disable iff (reset)
      advance && !request.action && frame_held_ff |->
         result.byte_dropped && !result.word_valid && !result.frame_error)
      else $error("byte taken while a frame is held");

   a_word_then_low: assert property (@(posedge clock) disable iff (reset)
      advance && result.word_valid |=> phase_ff == PH_LOW)
      else $error("word completed outside the high-byte phase");

   a_left_even: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LOW || phase_ff == PH_HIGH) |-> !bytes_left_ff[0])
      else $error("odd payload byte count");

   a_high_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HIGH |-> bytes_left_ff != '0)
      else $error("high byte with no payload left");

endmodule

// ===== src/sync_length_checksum_deframer.sv =====
// Top level of the FF FF length 00 / words / checksum deframer.
// Instantiates slcd_stage (request and result registers) and slcd_core.
//
//   channel  direction  tdata                                    tuser
//   req_     in         [7:0] rx_byte                            [0] action
//   rsp_     out        [15:0] word_value, [19:16] word_index,   [0] word_valid,
//                       [24:20] word_count, [31:25] zero         [1] frame_good,
//                                                                [2] frame_error,
//                                                                [3] byte_dropped
//
// Every request gives exactly one result; it passes through the request
// register, the decision logic and the result register.
// One request per cycle is sustained while rsp_tready stays high; the frame
// state updates as the request leaves the request register.
// Reset is synchronous; both registers empty and the deframer hunts for sync.
// A stalled rsp_ side backs up through both registers to req_tready.
`timescale 1ns / 1ps

module sync_length_checksum_deframer #(
   parameter int MAX_WORDS = slcd_pkg::SLCD_MAX_WORDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] word_value, [19:16] word_index, [24:20] word_count
   output logic [3:0]  rsp_tuser    // [0] word_valid, [1] frame_good, [2] frame_error,
                                    // [3] byte_dropped
);

   import slcd_pkg::*;

   localparam int REQ_W = $bits(slcd_request_type);
   localparam int RES_W = $bits(slcd_result_type);

   slcd_request_type req_in;
   slcd_request_type req_held;
   slcd_result_type  res_calc;
   slcd_result_type  res_out;
   logic [REQ_W-1:0] req_held_bits;
   logic [RES_W-1:0] res_out_bits;
   logic             req_held_valid;
   logic             res_ready;

   assign req_in.action  = req_tuser[0];
   assign req_in.rx_byte = req_tdata;

   slcd_stage #(.WIDTH(REQ_W)) u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_in),
      .out_valid (req_held_valid),
      .out_ready (res_ready),
      .out_data  (req_held_bits)
   );

   assign req_held = slcd_request_type'(req_held_bits);

   slcd_core #(.MAX_WORDS(MAX_WORDS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (req_held_valid && res_ready),
      .request (req_held),
      .result  (res_calc)
   );

   slcd_stage #(.WIDTH(RES_W)) u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_held_valid),
      .in_ready  (res_ready),
      .in_data   (res_calc),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res_out_bits)
   );

   assign res_out = slcd_result_type'(res_out_bits);

   assign rsp_tdata = {7'd0, res_out.word_count, res_out.word_index, res_out.word_value};
   assign rsp_tuser = {res_out.byte_dropped, res_out.frame_error,
                       res_out.frame_good, res_out.word_valid};

endmodule

// ===== dv/sync_length_checksum_deframer_test.sv =====
// Self-checking testbench for sync_length_checksum_deframer.
// Drives byte and release requests through the req_ stream and checks every
// rsp_ result against a scoreboard with its own deframer model; needs slcd_pkg.
`timescale 1ns / 1ps

module sync_length_checksum_deframer_test;
   import slcd_pkg::*;

   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;
   localparam int   RANDOM_REQUESTS = 1650;
   localparam int   CYCLE_LIMIT     = 200000;
   localparam int   LONG_HOLD       = 500;
   localparam int   MAX_LEN         = 2 * SLCD_MAX_WORDS + 3;

   typedef enum int {
      FL_NONE,
      FL_CHECKSUM,
      FL_LENGTH,
      FL_ZERO,
      FL_SYNC,
      FL_TRUNCATE
   } frame_flaw_type;

   // Deframer model plus the queue of results still to arrive
   class deframe_scoreboard;
      slcd_phase_type  phase;
      logic [7:0]      bytes_left;
      logic [7:0]      running_sum;
      logic [7:0]      low_byte;
      logic [4:0]      words_seen;
      logic            frame_held;
      slcd_result_type due_results[$];
      int              mismatches;
      int              checked;
      int              n_good;
      int              n_error;
      int              n_words;
      int              n_dropped;

      function new();
         phase       = PH_SYNC1;
         bytes_left  = '0;
         running_sum = '0;
         low_byte    = '0;
         words_seen  = '0;
         frame_held  = 1'b0;
         mismatches  = 0;
         checked     = 0;
         n_good      = 0;
         n_error     = 0;
         n_words     = 0;
         n_dropped   = 0;
      endfunction

      function void report(string msg);
         if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
         mismatches++;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void note_request(slcd_request_type req);
         slcd_result_type r;
         logic [7:0]      b;
         r = '0;
         b = req.rx_byte;
         if (req.action == ACT_RELEASE) begin
            frame_held = 1'b0;
         end else if (frame_held) begin
            r.byte_dropped = 1'b1;
            n_dropped++;
         end else begin
            case (phase)
               PH_SYNC2: begin
                  phase = (b == SLCD_SYNC_BYTE) ? PH_LEN : PH_SYNC1;
               end
               PH_LEN: begin
                  if (b < SLCD_HDR_BYTES || !b[0] || int'(b) > MAX_LEN) begin
                     r.frame_error = 1'b1;
                     phase = PH_SYNC1;
                  end else begin
                     bytes_left  = b - SLCD_HDR_BYTES;
                     running_sum = '0;
                     words_seen  = '0;
                     phase       = PH_ZERO;
                  end
               end
               PH_ZERO: begin
                  if (b == SLCD_ZERO_BYTE) begin
                     phase = PH_LOW;
                  end else begin
                     r.frame_error = 1'b1;
                     phase = PH_SYNC1;
                  end
               end
               PH_LOW: begin
                  running_sum = running_sum + b;
                  if (bytes_left == 8'd0) begin
                     // checksum byte: the sum over payload and checksum must wrap to zero
                     if (running_sum == 8'd0) begin
                        r.frame_good = 1'b1;
                        r.word_count = words_seen;
                        frame_held   = 1'b1;
                     end else begin
                        r.frame_error = 1'b1;
                     end
                     running_sum = '0;
                     words_seen  = '0;
                     phase       = PH_SYNC1;
                  end else begin
                     low_byte = b;
                     phase    = PH_HIGH;
                  end
               end
               PH_HIGH: begin
                  running_sum  = running_sum + b;
                  r.word_valid = 1'b1;
                  r.word_value = {b, low_byte};
                  r.word_index = words_seen[3:0];
                  words_seen   = words_seen + 5'd1;
                  bytes_left   = bytes_left - 8'd2;
                  phase        = PH_LOW;
                  n_words++;
               end
               default: begin
                  phase = (b == SLCD_SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
               end
            endcase
         end
         if (r.frame_good) n_good++;
         if (r.frame_error) n_error++;
         due_results.push_back(r);
      endfunction

      function void check_field(string name, int got, int want);
         if (got != want) begin
            report($sformatf("result %0d %s got 0x%0h, want 0x%0h", checked, name, got, want));
         end
      endfunction

      function void check_result(slcd_result_type got, logic [6:0] pad);
         slcd_result_type want;
         if (due_results.size() == 0) begin
            report($sformatf("result %0d arrived with nothing outstanding", checked));
         end else begin
            want = due_results.pop_front();
            check_field("word_valid", got.word_valid, want.word_valid);
            check_field("word_value", got.word_value, want.word_value);
            check_field("word_index", got.word_index, want.word_index);
            check_field("frame_good", got.frame_good, want.frame_good);
            check_field("frame_error", got.frame_error, want.frame_error);
            check_field("word_count", got.word_count, want.word_count);
            check_field("byte_dropped", got.byte_dropped, want.byte_dropped);
            check_field("tdata padding", pad, 0);
         end
         checked++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [0:0]  req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   deframe_scoreboard sb = new();

   int          issued = 0;
   int          burst_left = 0;
   int          cycles = 0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_count = 0;
   logic [7:0]  rx_cycle = 8'd0;
   logic [1:0]  rx_mode = 2'd0;

   sync_length_checksum_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off on request
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 8'd1;
      if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == LONG_HOLD - 1) hold_done <= 1'b1;
      end else begin
         if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
         case (rx_mode)
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2'd2: rsp_tready <= (rx_cycle[1:0] == 2'd0);
            default: rsp_tready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(slcd_result_type'{
            word_valid:   rsp_tuser[0],
            word_value:   rsp_tdata[15:0],
            word_index:   rsp_tdata[19:16],
            frame_good:   rsp_tuser[1],
            frame_error:  rsp_tuser[2],
            word_count:   rsp_tdata[24:20],
            byte_dropped: rsp_tuser[3]
         }, rsp_tdata[31:25]);
      end
   end

   // Offer one request in bursts with random gaps; return once it is accepted
   task automatic send_request(input logic act, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      // dropped bytes do not count towards the request budget
      if (act == ACT_RELEASE || !sb.frame_held) issued++;
      sb.note_request(slcd_request_type'{action: act, rx_byte: b});
   endtask

   function automatic logic [7:0] bad_length();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(0, 2));
         1: return 8'($urandom_range(0, 127) * 2);
         default: return 8'($urandom_range(MAX_LEN / 2 + 1, 127) * 2 + 1);
      endcase
   endfunction

   task automatic send_frame(input int nwords, input frame_flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] b;
      int         cut;
      sum = 8'd0;
      cut = $urandom_range(0, 2 * nwords);
      send_request(ACT_BYTE, SLCD_SYNC_BYTE);
      if (flaw == FL_SYNC) begin
         send_request(ACT_BYTE, 8'($urandom_range(0, 254)));
         return;
      end
      send_request(ACT_BYTE, SLCD_SYNC_BYTE);
      if (flaw == FL_LENGTH) begin
         send_request(ACT_BYTE, bad_length());
         return;
      end
      send_request(ACT_BYTE, 8'(2 * nwords + 3));
      if (flaw == FL_ZERO) begin
         send_request(ACT_BYTE, 8'($urandom_range(1, 255)));
         return;
      end
      send_request(ACT_BYTE, SLCD_ZERO_BYTE);
      for (int i = 0; i < 2 * nwords; i++) begin
         if (flaw == FL_TRUNCATE && i == cut) return;
         // a release in mid-frame must leave the frame untouched
         if ($urandom_range(0, 31) == 0) send_request(ACT_RELEASE, 8'($urandom));
         b = 8'($urandom);
         sum = sum + b;
         send_request(ACT_BYTE, b);
      end
      b = -sum;
      if (flaw == FL_CHECKSUM) b = b + 8'($urandom_range(1, 255));
      send_request(ACT_BYTE, b);
   endtask

   initial begin
      int pick;
      int nwords;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-word good frame, a byte while held, release, spare release
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h05);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'h34);
      send_request(ACT_BYTE, 8'h12);
      send_request(ACT_BYTE, 8'hBA);
      send_request(ACT_BYTE, 8'hAA);
      send_request(ACT_RELEASE, 8'hFF);
      send_request(ACT_RELEASE, 8'h00);
      // length below three
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h02);
      // second sync byte wrong
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h12);
      // nonzero fourth header byte
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h03);
      send_request(ACT_BYTE, 8'h01);
      // empty frame with zero checksum
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h03);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_BYTE, 8'h00);
      send_request(ACT_RELEASE, 8'h00);

      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         if (issued > RANDOM_REQUESTS / 2 && !hold_go) hold_go <= 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(5, SLCD_MAX_WORDS)
                                                 : $urandom_range(0, 4);
            send_frame(nwords, FL_NONE);
         end else if (pick < 90) begin
            nwords = $urandom_range(0, 4);
            send_frame(nwords, frame_flaw_type'($urandom_range(FL_CHECKSUM, FL_TRUNCATE)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_request(($urandom_range(0, 7) == 0) ? ACT_RELEASE : ACT_BYTE,
                            8'($urandom));
            end
         end
         if (sb.frame_held) begin
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 2)) send_request(ACT_BYTE, 8'($urandom));
            end
            send_request(ACT_RELEASE, 8'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d results: %0d good frames, %0d frame errors,", sb.checked,
               sb.n_good, sb.n_error);
      $display("%0d payload words, %0d dropped bytes, one long result stall.", sb.n_words,
               sb.n_dropped);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
